// ----- hdl/mre_pkg.sv -----
// Shared types and constants of the Modbus RTU master engine.
package mre_pkg;

  localparam int REGION_WORDS    = 256;
  localparam int REGION_AW       = $clog2(REGION_WORDS);
  localparam int IMG_WORDS       = 3 * REGION_WORDS;
  localparam int IMG_AW          = $clog2(IMG_WORDS);
  localparam int MAX_FRAME_BYTES = 256;
  localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 2);
  localparam int STAGING_WORDS   = 128;
  localparam int STG_AW          = $clog2(STAGING_WORDS);

  localparam logic [7:0] FN_READ   = 8'h03;
  localparam logic [7:0] FN_WRITE1 = 8'h06;
  localparam logic [7:0] FN_WRITEN = 8'h10;
  localparam logic [7:0] FN_MASK   = 8'h7F;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RESP  = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_IMAGE  = 2'd2;

  localparam logic [1:0] ST_REJECT = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_EXCEPT = 2'd2;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_READ  = 2'd1;
  localparam logic [1:0] PEND_WRITE = 2'd2;

  localparam logic [2:0] REG_FACTORY    = 3'd0;
  localparam logic [2:0] REG_SLAVE      = 3'd1;
  localparam logic [2:0] REG_SET_START  = 3'd2;
  localparam logic [2:0] REG_SET_END    = 3'd3;
  localparam logic [2:0] REG_HIST_START = 3'd4;
  localparam logic [2:0] REG_HIST_END   = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] reg_address;
    logic [7:0]  reg_count;
    logic [15:0] data_word;
    logic [7:0]  resp_byte;
    logic        resp_last;
    logic [9:0]  image_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [1:0]  status;
    logic [7:0]  error_code;
    logic [15:0] image_word;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctl_t;

endpackage

// ----- hdl/mre_crc.sv -----
// Bit-serial CRC-16 unit that folds one byte in a bit at a time.
module mre_crc import mre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  crc_ctl_t    ctl,
  input  logic [7:0]  data,
  output logic [15:0] crc,
  output logic        busy
);

  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      crc_nxt = CRC_INIT;
      cnt_nxt = 4'd0;
    end else if (ctl.start) begin
      crc_nxt = crc_r ^ {8'h00, data};
      cnt_nxt = 4'd8;
    end else if (cnt_r != 4'd0) begin
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= 4'd0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign crc  = crc_r;
  assign busy = (cnt_r != 4'd0);

endmodule

// ----- hdl/modbus_rtu_master_engine.sv -----
// Top level of the Modbus RTU master engine: sequencer, staging and image memories.
// After reset the block sweeps the 768-word register image to zero, one word per
// cycle, and takes no item during the sweep. One item is handled at a time.
// Every frame or reply byte runs through a bit-serial CRC unit. An accepted read
// reply then walks its staged words into the image at one word per cycle. Stalls on
// the result side hold back frame bytes, status items and query results.
module modbus_rtu_master_engine import mre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_TXB   = 4'd3;
  localparam logic [3:0] S_TXW   = 4'd4;
  localparam logic [3:0] S_TXC   = 4'd5;
  localparam logic [3:0] S_TXH   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_RXW   = 4'd8;
  localparam logic [3:0] S_JUDGE = 4'd9;
  localparam logic [3:0] S_CMT   = 4'd10;
  localparam logic [3:0] S_STAT  = 4'd11;
  localparam logic [3:0] S_QOUT  = 4'd12;

  localparam logic [2:0] M_READ = 3'd0;
  localparam logic [2:0] M_W1   = 3'd1;
  localparam logic [2:0] M_WM   = 3'd2;
  localparam logic [2:0] M_WN   = 3'd3;
  localparam logic [2:0] M_WL   = 3'd4;

  // Configuration registers.
  logic        factory_r;
  logic [7:0]  slave_r;
  logic [15:0] set_start_r, set_end_r, hist_start_r, hist_end_r;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factory_r    <= 1'b0;
      slave_r      <= 8'd1;
      set_start_r  <= 16'd0;
      set_end_r    <= 16'd0;
      hist_start_r <= 16'd0;
      hist_end_r   <= 16'd0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_FACTORY:    factory_r    <= pwdata[0];
        REG_SLAVE:      slave_r      <= pwdata[7:0];
        REG_SET_START:  set_start_r  <= pwdata[15:0];
        REG_SET_END:    set_end_r    <= pwdata[15:0];
        REG_HIST_START: hist_start_r <= pwdata[15:0];
        REG_HIST_END:   hist_end_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FACTORY:    prdata = {31'd0, factory_r};
      REG_SLAVE:      prdata = {24'd0, slave_r};
      REG_SET_START:  prdata = {16'd0, set_start_r};
      REG_SET_END:    prdata = {16'd0, set_end_r};
      REG_HIST_START: prdata = {16'd0, hist_start_r};
      REG_HIST_END:   prdata = {16'd0, hist_end_r};
      default:        prdata = 32'd0;
    endcase
  end

  // Sequencer state.
  logic [3:0]        state_r, state_nxt;
  in_item_t          it_r, it_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic [7:0]        efn_r, efn_nxt;
  logic [7:0]        ecnt_r, ecnt_nxt;
  logic [15:0]       taddr_r, taddr_nxt;
  logic [7:0]        wleft_r, wleft_nxt;
  logic [7:0]        held_r, held_nxt;
  logic [LEN_W-1:0]  rxlen_r, rxlen_nxt;
  logic [7:0]        rxfn_r, rxfn_nxt;
  logic [7:0]        rxcnt_r, rxcnt_nxt;
  logic [7:0]        rxhi_r, rxhi_nxt;
  logic              addr_ok_r, addr_ok_nxt;
  logic [7:0]        lerr_r, lerr_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [1:0]        region_r, region_nxt;
  logic [15:0]       off_r, off_nxt;
  logic [7:0]        k_r, k_nxt;
  logic              cmt_v_r, cmt_v_nxt;
  logic [16:0]       cmt_pos_r, cmt_pos_nxt;
  logic [IMG_AW-1:0] clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // CRC units.
  crc_ctl_t    txc_ctl, rxc_ctl;
  logic [7:0]  txc_data;
  logic [15:0] tx_crc, rx_crc;
  logic        tx_busy, rx_busy;

  mre_crc u_tx_crc (
    .clk(clk), .rst_n(rst_n), .ctl(txc_ctl), .data(txc_data), .crc(tx_crc), .busy(tx_busy)
  );
  mre_crc u_rx_crc (
    .clk(clk), .rst_n(rst_n), .ctl(rxc_ctl), .data(it_r.resp_byte), .crc(rx_crc),
    .busy(rx_busy)
  );

  // Staging memory.
  logic [15:0]       stg_mem [STAGING_WORDS];
  logic              stg_we;
  logic [STG_AW-1:0] stg_waddr;
  logic [15:0]       stg_rdata_r;

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= {rxhi_r, it_r.resp_byte};
    end
    stg_rdata_r <= stg_mem[k_r[STG_AW-1:0]];
  end

  // Register image memory.
  logic [15:0]       img_mem [IMG_WORDS];
  logic              img_we;
  logic [IMG_AW-1:0] img_waddr;
  logic [15:0]       img_wdata;
  logic [15:0]       img_rdata_r;

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_waddr] <= img_wdata;
    end
    img_rdata_r <= img_mem[it_r.image_index[IMG_AW-1:0]];
  end

  always_comb begin
    if (state_r == S_CLEAR) begin
      img_we    = 1'b1;
      img_waddr = clr_r;
      img_wdata = 16'd0;
    end else begin
      img_we    = cmt_v_r && (cmt_pos_r < 17'(REGION_WORDS));
      img_waddr = IMG_AW'({region_r, cmt_pos_r[REGION_AW-1:0]});
      img_wdata = stg_rdata_r;
    end
  end

  logic can_load;
  assign can_load  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  logic [2:0] nlast;
  logic       has_crc;
  logic [7:0] tx_byte;

  always_comb begin
    case (mode_r)
      M_READ, M_W1: nlast = 3'd5;
      M_WM:         nlast = 3'd7;
      M_WN:         nlast = 3'd1;
      default:      nlast = 3'd2;
    endcase
    has_crc = (mode_r != M_WM) && (mode_r != M_WN);
  end

  always_comb begin
    tx_byte = 8'h00;
    case (mode_r)
      M_READ, M_W1, M_WM: begin
        case (step_r)
          3'd0: tx_byte = slave_r;
          3'd1: tx_byte = (mode_r == M_READ) ? FN_READ :
                          (mode_r == M_W1) ? FN_WRITE1 : FN_WRITEN;
          3'd2: tx_byte = it_r.reg_address[15:8];
          3'd3: tx_byte = it_r.reg_address[7:0];
          3'd4: tx_byte = (mode_r == M_W1) ? it_r.data_word[15:8] : 8'h00;
          3'd5: tx_byte = (mode_r == M_W1) ? it_r.data_word[7:0] : it_r.reg_count;
          3'd6: tx_byte = {it_r.reg_count[6:0], 1'b0};
          default: tx_byte = it_r.data_word[15:8];
        endcase
      end
      default: begin
        case (step_r)
          3'd0:    tx_byte = held_r;
          3'd1:    tx_byte = it_r.data_word[15:8];
          default: tx_byte = it_r.data_word[7:0];
        endcase
      end
    endcase
  end

  logic [LEN_W-1:0] rx_d;
  logic [8:0]       twice_cnt;
  assign rx_d      = rxlen_r - LEN_W'(3);
  assign twice_cnt = {ecnt_r, 1'b0};

  always_comb begin
    state_nxt   = state_r;
    it_nxt      = it_r;
    mode_nxt    = mode_r;
    step_nxt    = step_r;
    pend_nxt    = pend_r;
    efn_nxt     = efn_r;
    ecnt_nxt    = ecnt_r;
    taddr_nxt   = taddr_r;
    wleft_nxt   = wleft_r;
    held_nxt    = held_r;
    rxlen_nxt   = rxlen_r;
    rxfn_nxt    = rxfn_r;
    rxcnt_nxt   = rxcnt_r;
    rxhi_nxt    = rxhi_r;
    addr_ok_nxt = addr_ok_r;
    lerr_nxt    = lerr_r;
    stat_nxt    = stat_r;
    region_nxt  = region_r;
    off_nxt     = off_r;
    k_nxt       = k_r;
    cmt_v_nxt   = 1'b0;
    cmt_pos_nxt = cmt_pos_r;
    clr_nxt     = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt     = out_r;
    txc_ctl     = '0;
    txc_data    = tx_byte;
    rxc_ctl     = '0;
    stg_we      = 1'b0;
    stg_waddr   = rx_d[STG_AW:1];

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + IMG_AW'(1);
        if (clr_r == IMG_AW'(IMG_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          it_nxt    = in_item;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        step_nxt  = 3'd0;
        state_nxt = S_IDLE;
        case (it_r.req_type)
          REQ_READ: begin
            wleft_nxt = 8'd0;
            if (!factory_r) begin
              efn_nxt       = FN_READ;
              ecnt_nxt      = it_r.reg_count;
              taddr_nxt     = it_r.reg_address;
              txc_ctl.clear = 1'b1;
              mode_nxt      = M_READ;
              state_nxt     = S_TXB;
            end
          end
          REQ_WRITE: begin
            if (factory_r) begin
              wleft_nxt = 8'd0;
            end else if (wleft_r == 8'd0) begin
              if (it_r.reg_count != 8'd0) begin
                pend_nxt      = PEND_NONE;
                ecnt_nxt      = it_r.reg_count;
                taddr_nxt     = it_r.reg_address;
                txc_ctl.clear = 1'b1;
                state_nxt     = S_TXB;
                if (it_r.reg_count == 8'd1) begin
                  efn_nxt  = FN_WRITE1;
                  mode_nxt = M_W1;
                end else begin
                  efn_nxt   = FN_WRITEN;
                  mode_nxt  = M_WM;
                  wleft_nxt = it_r.reg_count - 8'd1;
                end
              end
            end else begin
              wleft_nxt = wleft_r - 8'd1;
              mode_nxt  = (wleft_r == 8'd1) ? M_WL : M_WN;
              state_nxt = S_TXB;
            end
          end
          REQ_RESP: begin
            if (rxlen_r < LEN_W'(MAX_FRAME_BYTES)) begin
              if (rxlen_r == LEN_W'(0)) begin
                addr_ok_nxt = (it_r.resp_byte == slave_r);
              end else if (rxlen_r == LEN_W'(1)) begin
                rxfn_nxt = it_r.resp_byte;
              end else if (rxlen_r == LEN_W'(2)) begin
                rxcnt_nxt = it_r.resp_byte;
              end else if (!rx_d[0]) begin
                rxhi_nxt = it_r.resp_byte;
              end else if ((rx_d >> 1) < LEN_W'(STAGING_WORDS)) begin
                stg_we = 1'b1;
              end
            end
            rxc_ctl.start = 1'b1;
            if (rxlen_r <= LEN_W'(MAX_FRAME_BYTES)) begin
              rxlen_nxt = rxlen_r + LEN_W'(1);
            end
            state_nxt = S_RXW;
          end
          default: begin
            state_nxt = S_QOUT;
          end
        endcase
      end
      S_TXB: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{out_kind: KIND_FRAME, frame_byte: tx_byte, frame_last: 1'b0,
                      status: ST_REJECT, error_code: 8'd0, image_word: 16'd0};
          txc_ctl.start = 1'b1;
          state_nxt = S_TXW;
        end
      end
      S_TXW: begin
        if (!tx_busy) begin
          if (step_r == nlast) begin
            state_nxt = has_crc ? S_TXC : S_FIN;
          end else begin
            step_nxt  = step_r + 3'd1;
            state_nxt = S_TXB;
          end
        end
      end
      S_TXC: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{out_kind: KIND_FRAME, frame_byte: tx_crc[7:0], frame_last: 1'b0,
                      status: ST_REJECT, error_code: 8'd0, image_word: 16'd0};
          state_nxt = S_TXH;
        end
      end
      S_TXH: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{out_kind: KIND_FRAME, frame_byte: tx_crc[15:8], frame_last: 1'b1,
                      status: ST_REJECT, error_code: 8'd0, image_word: 16'd0};
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (mode_r == M_READ) begin
          pend_nxt = PEND_READ;
        end else begin
          held_nxt = it_r.data_word[7:0];
          if (mode_r == M_W1 || mode_r == M_WL) begin
            pend_nxt = PEND_WRITE;
          end
        end
        state_nxt = S_IDLE;
      end
      S_RXW: begin
        if (!rx_busy) begin
          state_nxt = it_r.resp_last ? S_JUDGE : S_IDLE;
        end
      end
      S_JUDGE: begin
        stat_nxt  = ST_REJECT;
        state_nxt = S_STAT;
        k_nxt     = 8'd0;
        if (taddr_r >= set_start_r && taddr_r <= set_end_r) begin
          region_nxt = 2'd0;
          off_nxt    = taddr_r - set_start_r;
        end else if (taddr_r >= hist_start_r && taddr_r <= hist_end_r) begin
          region_nxt = 2'd1;
          off_nxt    = taddr_r - hist_start_r;
        end else begin
          region_nxt = 2'd2;
          off_nxt    = taddr_r;
        end
        if (factory_r) begin
          pend_nxt = PEND_NONE;
        end else if (rxlen_r < LEN_W'(5) || rxlen_r > LEN_W'(MAX_FRAME_BYTES) ||
                     !addr_ok_r || pend_r == PEND_NONE) begin
          stat_nxt = ST_REJECT;
        end else begin
          lerr_nxt = 8'd0;
          if (rx_crc != 16'd0 || (rxfn_r & FN_MASK) != efn_r) begin
            stat_nxt = ST_REJECT;
          end else begin
            pend_nxt = PEND_NONE;
            if (rxfn_r[7]) begin
              lerr_nxt = rxcnt_r;
              stat_nxt = ST_EXCEPT;
            end else if (pend_r == PEND_WRITE) begin
              stat_nxt = ST_ACCEPT;
            end else if ({1'b0, rxcnt_r} == twice_cnt &&
                         rxlen_r == LEN_W'({1'b0, rxcnt_r} + 9'd5) &&
                         ecnt_r <= 8'(STAGING_WORDS)) begin
              stat_nxt  = ST_ACCEPT;
              state_nxt = S_CMT;
            end
          end
        end
        rxlen_nxt     = '0;
        addr_ok_nxt   = 1'b0;
        rxc_ctl.clear = 1'b1;
      end
      S_CMT: begin
        if (k_r < ecnt_r) begin
          cmt_v_nxt   = 1'b1;
          cmt_pos_nxt = {1'b0, off_r} + {9'd0, k_r};
          k_nxt       = k_r + 8'd1;
        end else begin
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{out_kind: KIND_STATUS, frame_byte: 8'd0, frame_last: 1'b0,
                      status: stat_r, error_code: lerr_r, image_word: 16'd0};
          state_nxt = S_IDLE;
        end
      end
      S_QOUT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{out_kind: KIND_IMAGE, frame_byte: 8'd0, frame_last: 1'b0,
                      status: ST_REJECT, error_code: 8'd0,
                      image_word: (it_r.image_index < 10'(IMG_WORDS)) ?
                                  img_rdata_r : 16'd0};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      mode_r      <= M_READ;
      step_r      <= 3'd0;
      pend_r      <= PEND_NONE;
      efn_r       <= 8'd0;
      ecnt_r      <= 8'd0;
      taddr_r     <= 16'd0;
      wleft_r     <= 8'd0;
      held_r      <= 8'd0;
      rxlen_r     <= '0;
      rxfn_r      <= 8'd0;
      rxcnt_r     <= 8'd0;
      rxhi_r      <= 8'd0;
      addr_ok_r   <= 1'b0;
      lerr_r      <= 8'd0;
      stat_r      <= ST_REJECT;
      k_r         <= 8'd0;
      cmt_v_r     <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      step_r      <= step_nxt;
      pend_r      <= pend_nxt;
      efn_r       <= efn_nxt;
      ecnt_r      <= ecnt_nxt;
      taddr_r     <= taddr_nxt;
      wleft_r     <= wleft_nxt;
      held_r      <= held_nxt;
      rxlen_r     <= rxlen_nxt;
      rxfn_r      <= rxfn_nxt;
      rxcnt_r     <= rxcnt_nxt;
      rxhi_r      <= rxhi_nxt;
      addr_ok_r   <= addr_ok_nxt;
      lerr_r      <= lerr_nxt;
      stat_r      <= stat_nxt;
      k_r         <= k_nxt;
      cmt_v_r     <= cmt_v_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r      <= it_nxt;
    region_r  <= region_nxt;
    off_r     <= off_nxt;
    cmt_pos_r <= cmt_pos_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ----- test/modbus_engine_monitor.sv -----
// Monitor for the Modbus RTU master engine: predicts every result item and checks it.
module modbus_engine_monitor import mre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          awaiting
);

  logic        factory;
  logic [7:0]  slave;
  logic [15:0] set_lo, set_hi, hist_lo, hist_hi;

  logic [1:0]  pend;
  logic [7:0]  exp_fn, exp_cnt, words_left, held_lo;
  logic [7:0]  rx_fn, rx_cnt, rx_hi, last_err;
  logic [15:0] target, tx_crc, rx_crc;
  int          rx_len;
  logic        addr_ok;
  logic [15:0] staged[STAGING_WORDS];
  logic [15:0] image[IMG_WORDS];

  out_item_t   expected_q[$];

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic out_item_t make_result(logic [1:0] kind, logic [7:0] fb, logic fl,
                                            logic [1:0] st, logic [7:0] ec,
                                            logic [15:0] iw);
    out_item_t r;
    r.out_kind = kind;
    r.frame_byte = fb;
    r.frame_last = fl;
    r.status = st;
    r.error_code = ec;
    r.image_word = iw;
    return r;
  endfunction

  task automatic emit_byte(logic [7:0] b);
    tx_crc = crc_next(tx_crc, b);
    expected_q.push_back(make_result(KIND_FRAME, b, 1'b0, ST_REJECT, 8'h00, 16'h0000));
  endtask

  task automatic emit_crc();
    logic [15:0] c;
    c = tx_crc;
    expected_q.push_back(make_result(KIND_FRAME, c[7:0], 1'b0, ST_REJECT, 8'h00, 16'h0));
    expected_q.push_back(make_result(KIND_FRAME, c[15:8], 1'b1, ST_REJECT, 8'h00, 16'h0));
  endtask

  task automatic commit_staged();
    int region, off;
    if (target >= set_lo && target <= set_hi) begin
      region = 0;
      off = target - set_lo;
    end else if (target >= hist_lo && target <= hist_hi) begin
      region = 1;
      off = target - hist_lo;
    end else begin
      region = 2;
      off = target;
    end
    for (int k = 0; k < exp_cnt && k < STAGING_WORDS; k++)
      if (off + k < REGION_WORDS) image[region * REGION_WORDS + off + k] = staged[k];
  endtask

  task automatic judge_reply(output logic [1:0] st);
    st = ST_REJECT;
    if (factory) begin
      pend = PEND_NONE;
      return;
    end
    if (rx_len < 5 || rx_len > MAX_FRAME_BYTES || !addr_ok) return;
    if (pend == PEND_NONE) return;
    last_err = 8'h00;
    if (rx_crc != 16'h0000) return;
    if ((rx_fn & FN_MASK) != exp_fn) return;
    if (pend == PEND_READ) begin
      pend = PEND_NONE;
      if (rx_fn[7]) begin
        last_err = rx_cnt;
        st = ST_EXCEPT;
        return;
      end
      if (int'(rx_cnt) != 2 * int'(exp_cnt)) return;
      if (rx_len != int'(rx_cnt) + 5) return;
      if (exp_cnt > STAGING_WORDS) return;
      commit_staged();
      st = ST_ACCEPT;
      return;
    end
    pend = PEND_NONE;
    if (rx_fn[7]) begin
      last_err = rx_cnt;
      st = ST_EXCEPT;
      return;
    end
    st = ST_ACCEPT;
  endtask

  task automatic predict_item(in_item_t it);
    logic [1:0] st;
    int d;
    case (it.req_type)
      REQ_READ: begin
        words_left = 8'h00;
        if (!factory) begin
          exp_fn = FN_READ;
          exp_cnt = it.reg_count;
          target = it.reg_address;
          tx_crc = CRC_INIT;
          emit_byte(slave);
          emit_byte(FN_READ);
          emit_byte(it.reg_address[15:8]);
          emit_byte(it.reg_address[7:0]);
          emit_byte(8'h00);
          emit_byte(it.reg_count);
          emit_crc();
          pend = PEND_READ;
        end
      end
      REQ_WRITE: begin
        if (factory) begin
          words_left = 8'h00;
        end else if (words_left == 8'h00) begin
          if (it.reg_count != 8'h00) begin
            pend = PEND_NONE;
            exp_cnt = it.reg_count;
            target = it.reg_address;
            tx_crc = CRC_INIT;
            emit_byte(slave);
            if (it.reg_count == 8'd1) begin
              exp_fn = FN_WRITE1;
              emit_byte(FN_WRITE1);
              emit_byte(it.reg_address[15:8]);
              emit_byte(it.reg_address[7:0]);
              emit_byte(it.data_word[15:8]);
              emit_byte(it.data_word[7:0]);
              emit_crc();
              pend = PEND_WRITE;
            end else begin
              exp_fn = FN_WRITEN;
              emit_byte(FN_WRITEN);
              emit_byte(it.reg_address[15:8]);
              emit_byte(it.reg_address[7:0]);
              emit_byte(8'h00);
              emit_byte(it.reg_count);
              emit_byte({it.reg_count[6:0], 1'b0});
              emit_byte(it.data_word[15:8]);
              held_lo = it.data_word[7:0];
              words_left = it.reg_count - 8'd1;
            end
          end
        end else begin
          emit_byte(held_lo);
          emit_byte(it.data_word[15:8]);
          held_lo = it.data_word[7:0];
          words_left = words_left - 8'd1;
          if (words_left == 8'h00) begin
            emit_byte(held_lo);
            emit_crc();
            pend = PEND_WRITE;
          end
        end
      end
      REQ_RESP: begin
        if (rx_len < MAX_FRAME_BYTES) begin
          if (rx_len == 0) addr_ok = (it.resp_byte == slave);
          else if (rx_len == 1) rx_fn = it.resp_byte;
          else if (rx_len == 2) rx_cnt = it.resp_byte;
          else begin
            d = rx_len - 3;
            if (d % 2 == 0) rx_hi = it.resp_byte;
            else if (d / 2 < STAGING_WORDS) staged[d / 2] = {rx_hi, it.resp_byte};
          end
        end
        rx_crc = crc_next(rx_crc, it.resp_byte);
        if (rx_len <= MAX_FRAME_BYTES) rx_len++;
        if (it.resp_last) begin
          judge_reply(st);
          expected_q.push_back(make_result(KIND_STATUS, 8'h00, 1'b0, st, last_err, 16'h0));
          rx_len = 0;
          rx_crc = CRC_INIT;
          addr_ok = 1'b0;
        end
      end
      default: begin
        expected_q.push_back(make_result(KIND_IMAGE, 8'h00, 1'b0, ST_REJECT, 8'h00,
          (it.image_index < IMG_WORDS) ? image[it.image_index] : 16'h0000));
      end
    endcase
  endtask

  task automatic report_mismatch(string what, int want, int got);
    $display("MISMATCH at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      factory = 1'b0;
      slave = 8'd1;
      set_lo = 16'h0; set_hi = 16'h0; hist_lo = 16'h0; hist_hi = 16'h0;
      pend = PEND_NONE;
      exp_fn = 8'h00; exp_cnt = 8'h00; words_left = 8'h00; held_lo = 8'h00;
      rx_fn = 8'h00; rx_cnt = 8'h00; rx_hi = 8'h00; last_err = 8'h00;
      target = 16'h0; tx_crc = CRC_INIT; rx_crc = CRC_INIT;
      rx_len = 0;
      addr_ok = 1'b0;
      for (int k = 0; k < STAGING_WORDS; k++) staged[k] = 16'h0;
      for (int k = 0; k < IMG_WORDS; k++) image[k] = 16'h0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_FACTORY:    factory = pwdata[0];
          REG_SLAVE:      slave = pwdata[7:0];
          REG_SET_START:  set_lo = pwdata[15:0];
          REG_SET_END:    set_hi = pwdata[15:0];
          REG_HIST_START: hist_lo = pwdata[15:0];
          REG_HIST_END:   hist_hi = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_item(in_item);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result item", 0, int'(out_item.out_kind));
        end else begin
          want = expected_q.pop_front();
          if (want.out_kind != out_item.out_kind)
            report_mismatch("out_kind", want.out_kind, out_item.out_kind);
          if (want.frame_byte != out_item.frame_byte)
            report_mismatch("frame_byte", want.frame_byte, out_item.frame_byte);
          if (want.frame_last != out_item.frame_last)
            report_mismatch("frame_last", want.frame_last, out_item.frame_last);
          if (want.status != out_item.status)
            report_mismatch("status", want.status, out_item.status);
          if (want.error_code != out_item.error_code)
            report_mismatch("error_code", want.error_code, out_item.error_code);
          if (want.image_word != out_item.image_word)
            report_mismatch("image_word", want.image_word, out_item.image_word);
        end
      end
    end
    awaiting = expected_q.size();
  end

  initial begin
    mismatches = 0;
    awaiting = 0;
  end

endmodule

// ----- test/modbus_rtu_master_engine_tb.sv -----
// Testbench top for the Modbus RTU master engine: clock, reset, stimulus and verdict.
module modbus_rtu_master_engine_tb;
  import mre_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL   = 450;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          awaiting;
  int          cycles;
  int          items_sent;
  int          reads_done, writes_done, replies_done, queries_done;
  int          idle_pct, stall_pct;
  int          hold_left;
  logic        hold_go;
  logic [7:0]  cur_slave;
  logic [15:0] cur_set_lo, cur_hist_lo;

  modbus_rtu_master_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  modbus_engine_monitor u_monitor (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles.", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (hold_go) begin
        hold_go = 1'b0;
        hold_left = 3000;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic in_item_t noise_item();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_item_t)-1:0];
  endfunction

  task automatic send(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic configure(logic fm, logic [7:0] sa, logic [15:0] s0, logic [15:0] s1,
                           logic [15:0] h0, logic [15:0] h1);
    settle();
    apb_write(REG_FACTORY, {31'd0, fm});
    apb_write(REG_SLAVE, {24'd0, sa});
    apb_write(REG_SET_START, {16'd0, s0});
    apb_write(REG_SET_END, {16'd0, s1});
    apb_write(REG_HIST_START, {16'd0, h0});
    apb_write(REG_HIST_END, {16'd0, h1});
    cur_slave = sa;
    cur_set_lo = s0;
    cur_hist_lo = h0;
  endtask

  task automatic send_reply(logic [7:0] bytes[$]);
    in_item_t it;
    foreach (bytes[k]) begin
      it = noise_item();
      it.req_type = REQ_RESP;
      it.resp_byte = bytes[k];
      it.resp_last = (k == bytes.size() - 1);
      send(it);
    end
    replies_done++;
  endtask

  // Reply variants: 0 good, 1 exception, 2 corrupted byte, 3 wrong slave, 4 no reply.
  task automatic reply_to(logic [7:0] fn, logic [7:0] body[$], int variant);
    logic [7:0]  q[$];
    logic [15:0] c;
    int          pos;
    if (variant == 4) return;
    q = {cur_slave, fn};
    if (variant == 1) begin
      q[1] = fn | 8'h80;
      q.push_back($urandom_range(255));
    end else begin
      foreach (body[k]) q.push_back(body[k]);
    end
    c = CRC_INIT;
    foreach (q[k]) c = crc_next(c, q[k]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    if (variant == 2) begin
      pos = $urandom_range(q.size() - 1);
      q[pos] = q[pos] ^ (8'd1 << $urandom_range(7));
    end
    if (variant == 3) q[0] = cur_slave + 8'd1 + 8'($urandom_range(253));
    send_reply(q);
  endtask

  // A count above the staging depth can never be accepted, so its reply stays short.
  task automatic do_read(logic [15:0] addr, logic [7:0] cnt, int variant);
    in_item_t    it;
    logic [7:0]  body[$];
    int          nb;
    it = noise_item();
    it.req_type = REQ_READ;
    it.reg_address = addr;
    it.reg_count = cnt;
    send(it);
    reads_done++;
    nb = (int'(cnt) > STAGING_WORDS) ? 4 : 2 * int'(cnt);
    body = {8'(2 * cnt)};
    for (int k = 0; k < nb; k++) body.push_back($urandom_range(255));
    reply_to(FN_READ, body, variant);
  endtask

  task automatic do_write(logic [15:0] addr, logic [7:0] cnt, int variant);
    in_item_t    it;
    logic [7:0]  body[$];
    logic [15:0] first;
    for (int k = 0; k < cnt; k++) begin
      it = noise_item();
      it.req_type = REQ_WRITE;
      if (k == 0) begin
        it.reg_address = addr;
        it.reg_count = cnt;
        first = it.data_word;
      end
      send(it);
    end
    writes_done++;
    if (cnt == 8'd1) begin
      body = {addr[15:8], addr[7:0], first[15:8], first[7:0]};
      reply_to(FN_WRITE1, body, variant);
    end else begin
      body = {addr[15:8], addr[7:0], 8'h00, cnt};
      reply_to(FN_WRITEN, body, variant);
    end
  endtask

  task automatic do_query(logic [9:0] idx);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_QUERY;
    it.image_index = idx;
    send(it);
    queries_done++;
  endtask

  function automatic int pick_variant();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 75) return 1;
    if (r < 85) return 2;
    if (r < 92) return 3;
    return 4;
  endfunction

  function automatic logic [15:0] pick_address();
    int r;
    r = $urandom_range(9);
    if (r < 4) return cur_set_lo + 16'($urandom_range(250));
    if (r < 7) return cur_hist_lo + 16'($urandom_range(250));
    if (r < 9) return 16'($urandom_range(260));
    return 16'($urandom());
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'($urandom_range(1, 8));
    if (r < 95) return 8'($urandom_range(9, 128));
    return 8'($urandom_range(129, 255));
  endfunction

  task automatic random_traffic(int goal);
    int          r;
    logic [7:0]  q[$];
    logic [7:0]  wc;
    in_item_t    it;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 35) begin
        do_read(pick_address(), pick_count(), pick_variant());
      end else if (r < 58) begin
        wc = ($urandom_range(9) == 0) ? pick_count() : 8'($urandom_range(1, 6));
        do_write(pick_address(), wc, pick_variant());
      end else if (r < 78) begin
        do_query($urandom_range(3) == 0 ? 10'($urandom()) : 10'($urandom_range(767)));
      end else if (r < 90) begin
        q.delete();
        repeat ($urandom_range(1, 12)) q.push_back($urandom_range(255));
        if ($urandom_range(1)) q[0] = cur_slave;
        send_reply(q);
      end else begin
        it = noise_item();
        send(it);
      end
    end
  endtask

  initial begin
    logic [7:0] q[$];
    in_item_t   it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_go = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    reads_done = 0; writes_done = 0; replies_done = 0; queries_done = 0;
    cur_slave = 8'd1;
    cur_set_lo = 16'h0;
    cur_hist_lo = 16'h0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    configure(1'b0, 8'h11, 16'h0100, 16'h01FF, 16'h1000, 16'h10FF);
    do_query(10'd0);
    do_read(16'h0100, 8'd2, 0);
    do_query(10'd0);
    do_query(10'd1);
    do_read(16'hFFFF, 8'hFF, 1);
    do_write(16'h0000, 8'd1, 0);
    do_write(16'h1000, 8'd3, 1);
    it = noise_item();
    it.req_type = REQ_WRITE;
    it.reg_count = 8'h00;
    send(it);
    do_read(16'h10FE, 8'd4, 2);
    do_read(16'h0200, 8'd1, 3);
    q = {8'h11, 8'h03};
    send_reply(q);
    do_read(16'h0010, 8'd1, 4);
    reply_to(FN_WRITE1, {8'h00, 8'h10, 8'h00, 8'h01}, 0);
    reply_to(FN_READ, {8'h02, 8'hAB, 8'hCD}, 0);
    do_read(16'h0001, 8'd1, 0);
    q.delete();
    repeat (260) q.push_back($urandom_range(255));
    q[0] = 8'h11;
    send_reply(q);
    do_query(10'd767);
    do_query(10'h3FF);
    do_query(10'd256);

    configure(1'b0, 8'd247, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    random_traffic(items_sent + 20);

    idle_pct = 87;
    configure(1'b0, 8'd1, 16'hFF00, 16'hFFFF, 16'h0000, 16'h00FF);
    random_traffic(items_sent + 20);

    idle_pct = 0;
    stall_pct = 87;
    configure(1'b1, 8'h5A, 16'h0000, 16'h0100, 16'h0080, 16'h0300);
    random_traffic(items_sent + 15);

    configure(1'b0, 8'h5A, 16'h0000, 16'h0100, 16'h0080, 16'h0300);
    hold_go = 1'b1;
    random_traffic(items_sent + 20);

    idle_pct = 23;
    stall_pct = 23;
    configure(1'b0, 8'hA5, 16'h8000, 16'h80FF, 16'hFFFF, 16'hFFFF);
    random_traffic((items_sent + 20 > ITEM_GOAL) ? items_sent + 20 : ITEM_GOAL);

    settle();
    $display("Covered %0d items: %0d reads, %0d writes, %0d replies, %0d queries.",
             items_sent, reads_done, writes_done, replies_done, queries_done);
    $display("Idle and stall mixes, factory mode, window extremes and a long hold-off.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
